// File: hdl/ljs_pkg.sv
package ljs_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ID_W        = 16;
   localparam int ARR_W       = 16;
   localparam int SVC_W       = 16;
   localparam int TIME_W      = 24;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_LATE = 2'd2,
      ST_ZERO = 2'd3
   } status_type;

   // job record, job_id in the low bits
   typedef struct packed {
      logic [SVC_W-1:0] service;
      logic [ARR_W-1:0] arrival;
      logic [ID_W-1:0]  job_id;
   } job_rec_type;

   typedef struct packed {
      status_type        status;
      logic              busy_res;
      logic [ID_W-1:0]   run_id;
      logic [SVC_W-1:0]  remaining;
      logic              all_done;
      logic [TIME_W-1:0] time_now;
   } rsp_type;

endpackage

// File: hdl/ljs_ram.sv
module ljs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ljs_ctrl.sv
module ljs_ctrl
   import ljs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  job_rec_type req_job,
   output logic        res_valid,
   output rsp_type     res,
   input  logic        res_ready
);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_LD_CMP  = 9'b000000010,
      S_LD_PUT  = 9'b000000100,
      S_LD_DONE = 9'b000001000,
      S_TK_CMP  = 9'b000010000,
      S_TK_POP  = 9'b000100000,
      S_TK_IDX  = 9'b001000000,
      S_TK_REC  = 9'b010000000,
      S_TK_RUN  = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  np_ff, np_in;
   logic [CNT_W-1:0]  sp_ff, sp_in;
   logic [ID_W-1:0]   cur_id_ff, cur_id_in;
   logic [SVC_W-1:0]  cur_left_ff, cur_left_in;
   logic              running_ff, running_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic              started_ff, started_in;
   status_type        status_ff, status_in;
   job_rec_type       job_ff, job_in;
   logic [IDX_W-1:0]  k_ff, k_in;

   logic              tbl_we;
   logic [IDX_W-1:0]  tbl_waddr, tbl_raddr;
   job_rec_type       tbl_wdata, tbl_rdata;
   logic              stk_we;
   logic [IDX_W-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;

   logic [CNT_W-1:0]  cnt_dec, np_inc, sp_inc, sp_dec;
   logic [IDX_W-1:0]  k_inc, k_dec;
   logic [TIME_W-1:0] arr_ext;
   logic              run_next;

   ljs_ram #(.WIDTH($bits(job_rec_type)), .DEPTH(TABLE_DEPTH)) u_job_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   ljs_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign cnt_dec = count_ff - 1'b1;
   assign np_inc  = np_ff + 1'b1;
   assign sp_inc  = sp_ff + 1'b1;
   assign sp_dec  = sp_ff - 1'b1;
   assign k_inc   = k_ff + 1'b1;
   assign k_dec   = k_ff - 1'b1;
   assign arr_ext = {{(TIME_W - ARR_W){1'b0}}, tbl_rdata.arrival};
   assign run_next = running_ff && (cur_left_ff != SVC_W'(1));

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      np_in       = np_ff;
      sp_in       = sp_ff;
      cur_id_in   = cur_id_ff;
      cur_left_in = cur_left_ff;
      running_in  = running_ff;
      time_in     = time_ff;
      started_in  = started_ff;
      status_in   = status_ff;
      job_in      = job_ff;
      k_in        = k_ff;
      tbl_we      = 1'b0;
      tbl_waddr   = '0;
      tbl_wdata   = job_ff;
      tbl_raddr   = '0;
      stk_we      = 1'b0;
      stk_waddr   = sp_ff[IDX_W-1:0];
      stk_wdata   = np_ff[IDX_W-1:0];
      stk_raddr   = sp_dec[IDX_W-1:0];
      res_valid   = 1'b0;
      res         = '0;
      res.time_now = time_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_LOAD) begin
                  job_in = req_job;
                  if (started_ff) begin
                     status_in = ST_LATE;
                     state_in  = S_LD_DONE;
                  end else if (req_job.service == '0) begin
                     status_in = ST_ZERO;
                     state_in  = S_LD_DONE;
                  end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_LD_DONE;
                  end else begin
                     status_in = ST_OK;
                     if (count_ff == '0) begin
                        state_in = S_LD_PUT;
                     end else begin
                        k_in      = cnt_dec[IDX_W-1:0];
                        tbl_raddr = cnt_dec[IDX_W-1:0];
                        state_in  = S_LD_CMP;
                     end
                  end
               end else begin
                  started_in = 1'b1;
                  if (running_ff) begin
                     state_in = S_TK_RUN;
                  end else if (np_ff < count_ff) begin
                     tbl_raddr = np_ff[IDX_W-1:0];
                     state_in  = S_TK_CMP;
                  end else begin
                     state_in = S_TK_POP;
                  end
               end
            end
         end

         // walk down from the top, moving later arrivals up one slot
         S_LD_CMP: begin
            tbl_we    = 1'b1;
            tbl_waddr = k_inc;
            if (tbl_rdata.arrival > job_ff.arrival) begin
               tbl_wdata = tbl_rdata;
               if (k_ff == '0) begin
                  state_in = S_LD_PUT;
               end else begin
                  k_in      = k_dec;
                  tbl_raddr = k_dec;
               end
            end else begin
               tbl_wdata = job_ff;
               count_in  = count_ff + 1'b1;
               state_in  = S_LD_DONE;
            end
         end

         S_LD_PUT: begin
            tbl_we    = 1'b1;
            tbl_waddr = '0;
            tbl_wdata = job_ff;
            count_in  = count_ff + 1'b1;
            state_in  = S_LD_DONE;
         end

         S_LD_DONE: begin
            res_valid    = 1'b1;
            res.status   = status_ff;
            res.all_done = (np_ff >= count_ff) && (sp_ff == '0) && !running_ff;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         // push every arrived job in table order
         S_TK_CMP: begin
            if (arr_ext <= time_ff) begin
               if (sp_ff < CNT_W'(TABLE_DEPTH)) begin
                  stk_we = 1'b1;
                  sp_in  = sp_inc;
               end
               np_in = np_inc;
               if (np_inc < count_ff) begin
                  tbl_raddr = np_inc[IDX_W-1:0];
               end else begin
                  state_in = S_TK_POP;
               end
            end else begin
               state_in = S_TK_POP;
            end
         end

         S_TK_POP: begin
            if (sp_ff != '0) begin
               sp_in    = sp_dec;
               state_in = S_TK_IDX;
            end else begin
               state_in = S_TK_RUN;
            end
         end

         S_TK_IDX: begin
            tbl_raddr = stk_rdata;
            state_in  = S_TK_REC;
         end

         S_TK_REC: begin
            cur_id_in   = tbl_rdata.job_id;
            cur_left_in = tbl_rdata.service;
            running_in  = (tbl_rdata.service != '0);
            state_in    = S_TK_RUN;
         end

         S_TK_RUN: begin
            res_valid    = 1'b1;
            res.status   = ST_OK;
            res.busy_res = running_ff;
            res.run_id   = running_ff ? cur_id_ff : '0;
            res.remaining = running_ff ? cur_left_ff : '0;
            res.all_done = (np_ff >= count_ff) && (sp_ff == '0) && !run_next;
            if (res_ready) begin
               if (running_ff) begin
                  cur_left_in = cur_left_ff - 1'b1;
               end
               running_in = run_next;
               if (time_ff != TIME_MAX) begin
                  time_in = time_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         np_ff       <= '0;
         sp_ff       <= '0;
         cur_id_ff   <= '0;
         cur_left_ff <= '0;
         running_ff  <= 1'b0;
         time_ff     <= '0;
         started_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         np_ff       <= np_in;
         sp_ff       <= sp_in;
         cur_id_ff   <= cur_id_in;
         cur_left_ff <= cur_left_in;
         running_ff  <= running_in;
         time_ff     <= time_in;
         started_ff  <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      job_ff    <= job_in;
      k_ff      <= k_in;
   end

endmodule

// File: hdl/ljs_rsp_reg.sv
module ljs_rsp_reg
   import ljs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hdl/lifo_job_scheduler.sv
// channel | dir | tdata (low bit up)                    | tuser
// req_    | in  | job_id, arrival, service              | func
// rsp_    | out | run_id, remaining, all_done, time_now | status, busy_res
//
// Loads and ticks are both paced by the single read port of the job table RAM, walked
// one entry per cycle.
// One item is in work at a time; req_tready is high only while the sequencer is idle.
// Results leave through the output register; while it holds a result
// on rsp_tready, the next one waits in the sequencer and req_tready stays low.
// Reset is synchronous; the job table and ready stack are not cleared, only counts and state.
module lifo_job_scheduler
   import ljs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // job_id[15:0], arrival[31:16], service[47:32]
   input  logic [0:0]  req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // run_id[15:0], remaining[31:16], all_done[32],
                                    // time_now[56:33], zero pad[63:57]
   output logic [2:0]  rsp_tuser    // status[1:0], busy_res[2]
);

   job_rec_type req_job;
   rsp_type     res, rsp;
   logic        res_valid, res_ready;

   // record layout matches tdata packing
   assign req_job = req_tdata;

   ljs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_func  (req_tuser[0]),
      .req_job   (req_job),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // output stage: decouples result transfer from the sequencer
   ljs_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (res_ready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {7'd0, rsp.time_now, rsp.all_done, rsp.remaining, rsp.run_id};
   assign rsp_tuser = {rsp.busy_res, rsp.status};

endmodule

// File: hdl/ljs_checker.sv
module ljs_checker
   import ljs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> rsp_tdata[31:0] == 32'd0)
      else $error("idle result carries job data");

   a_busy_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |->
         rsp_tdata[31:16] != 16'd0 && status_type'(rsp_tuser[1:0]) == ST_OK)
      else $error("busy result with no work left or bad status");

   a_busy_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] && rsp_tdata[31:16] > 16'd1 |-> !rsp_tdata[32])
      else $error("all_done while a job still has work");

endmodule

bind lifo_job_scheduler ljs_checker u_ljs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: test/ljs_monitor.sv
`timescale 1ns / 1ps

module ljs_monitor
   import ljs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // job_id[15:0], arrival[31:16], service[47:32]
   input  logic [0:0]  req_tuser,   // func[0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // run_id[15:0], remaining[31:16], all_done[32],
                                    // time_now[56:33], zero pad[63:57]
   input  logic [2:0]  rsp_tuser,   // status[1:0], busy_res[2]
   output int          err_count,
   output int          due_count,
   output int          busy_ticks
);

   // shadow copy of the scheduler
   job_rec_type       jobs [TABLE_DEPTH];
   logic [IDX_W-1:0]  ready_idx [TABLE_DEPTH];
   int unsigned       n_jobs;
   int unsigned       next_due;
   int unsigned       depth;
   logic [ID_W-1:0]   cur_id;
   logic [SVC_W-1:0]  cur_left;
   logic              running;
   logic              started;
   logic [TIME_W-1:0] now_t;

   rsp_type           due_results [$];
   int                n_err = 0;
   int                n_busy = 0;

   task automatic schedule_step(input logic func, input job_rec_type job,
                                output rsp_type res);
      int unsigned      pos;
      int unsigned      k;
      logic [IDX_W-1:0] idx;
      res          = '0;
      res.time_now = now_t;
      if (func == FUNC_LOAD) begin
         if (started) begin
            res.status = ST_LATE;
         end else if (job.service == '0) begin
            res.status = ST_ZERO;
         end else if (n_jobs >= TABLE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // stable insert: after every job with equal or earlier arrival
            pos = 0;
            while (pos < n_jobs && jobs[pos].arrival <= job.arrival)
               pos++;
            for (k = n_jobs; k > pos; k--)
               jobs[k] = jobs[k-1];
            jobs[pos]  = job;
            n_jobs++;
            res.status = ST_OK;
         end
      end else begin
         started = 1'b1;
         if (!running) begin
            while (next_due < n_jobs && jobs[next_due].arrival <= now_t) begin
               if (depth < TABLE_DEPTH) begin
                  ready_idx[depth] = IDX_W'(next_due);
                  depth++;
               end
               next_due++;
            end
            if (depth > 0) begin
               depth--;
               idx      = ready_idx[depth];
               cur_id   = jobs[idx].job_id;
               cur_left = jobs[idx].service;
               running  = (cur_left != '0);
            end
         end
         if (running) begin
            res.busy_res  = 1'b1;
            res.run_id    = cur_id;
            res.remaining = cur_left;
            cur_left--;
            if (cur_left == '0)
               running = 1'b0;
         end
         if (now_t != TIME_MAX)
            now_t++;
      end
      res.all_done = (next_due >= n_jobs && depth == 0 && !running);
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      rsp_type act_r;
      if (reset) begin
         n_jobs   = 0;
         next_due = 0;
         depth    = 0;
         cur_id   = '0;
         cur_left = '0;
         running  = 1'b0;
         started  = 1'b0;
         now_t    = '0;
         due_results.delete();
      end else begin
         // result side first: a result never belongs to an item taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            act_r.status    = status_type'(rsp_tuser[1:0]);
            act_r.busy_res  = rsp_tuser[2];
            act_r.run_id    = rsp_tdata[15:0];
            act_r.remaining = rsp_tdata[31:16];
            act_r.all_done  = rsp_tdata[32];
            act_r.time_now  = rsp_tdata[56:33];
            if (act_r.busy_res === 1'b1)
               n_busy++;
            if (due_results.size() == 0) begin
               n_err++;
               if (n_err <= 10)
                  $display("%0t: result transfer with nothing expected (id %h)",
                           $time, act_r.run_id);
            end else begin
               exp_r = due_results.pop_front();
               if (act_r.status !== exp_r.status || act_r.busy_res !== exp_r.busy_res ||
                   act_r.run_id !== exp_r.run_id || act_r.remaining !== exp_r.remaining ||
                   act_r.all_done !== exp_r.all_done || act_r.time_now !== exp_r.time_now)
               begin
                  n_err++;
                  if (n_err <= 10) begin
                     $display("%0t: mismatch", $time);
                     $display("   exp: status %0d busy %b id %h left %0d done %b time %0d",
                              exp_r.status, exp_r.busy_res, exp_r.run_id, exp_r.remaining,
                              exp_r.all_done, exp_r.time_now);
                     $display("   got: status %0d busy %b id %h left %0d done %b time %0d",
                              act_r.status, act_r.busy_res, act_r.run_id, act_r.remaining,
                              act_r.all_done, act_r.time_now);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            schedule_step(req_tuser[0], job_rec_type'(req_tdata), exp_r);
            due_results.push_back(exp_r);
         end
      end
      err_count  <= n_err;
      due_count  <= due_results.size();
      busy_ticks <= n_busy;
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import ljs_pkg::*;

   localparam int RANDOM_ITEMS = 580;     // on top of the directed opening
   localparam int LIMIT_CYCLES = 200000;  // well above the slowest legal run
   localparam int HOLD_AT      = 150;     // result count at which the receiver stalls
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 40;      // longest tick plus a full receiver gap

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // job_id[15:0], arrival[31:16], service[47:32]
   logic [0:0]  req_tuser  = '0;   // func[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // run_id, remaining, all_done, time_now, pad
   logic [2:0]  rsp_tuser;         // status[1:0], busy_res[2]

   int err_count;
   int due_count;
   int busy_ticks;
   int n_loads     = 0;
   int n_ticks     = 0;
   int n_taken     = 0;
   int cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   lifo_job_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Watches both channels, predicts every result and counts the failures.
   ljs_monitor u_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .err_count  (err_count),
      .due_count  (due_count),
      .busy_ticks (busy_ticks)
   );

   // Offer one item and wait for its transfer. The idle gap is drawn per item;
   // every third stretch of 50 items goes back to back. With no gap, tvalid stays
   // high from the previous transfer, so it is never dropped and raised in one step.
   task automatic send_item(input logic func, input logic [15:0] id,
                            input logic [15:0] arr, input logic [15:0] svc);
      int gap;
      gap = ((n_loads + n_ticks) % 150 >= 100) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {svc, arr, id};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      if (func == FUNC_LOAD)
         n_loads++;
      else
         n_ticks++;
   endtask

   // Receiver: random stall before each result, a quiet stretch now and then, and
   // one long hold-off so that the result register fills and req_tready drops.
   initial begin
      int gap;
      forever begin
         if (n_taken == HOLD_AT)
            gap = HOLD_CYCLES;
         else if (n_taken % 120 >= 80)
            gap = 0;
         else
            gap = $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         n_taken++;
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still due", cycle_count, due_count);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed opening ---
      // zero service into an empty table is thrown away
      send_item(FUNC_LOAD, 16'h5a5a, 16'd3, 16'h0000);
      // extremes of id, earliest arrival, shortest job
      send_item(FUNC_LOAD, 16'h0000, 16'h0000, 16'h0001);
      // same arrival as the one before: must sort behind it
      send_item(FUNC_LOAD, 16'hffff, 16'h0000, 16'd3);
      // fill the table; small arrivals give idle ticks, shared arrivals and
      // several jobs becoming ready while another one runs
      for (int i = 0; i < TABLE_DEPTH - 2; i++)
         send_item(FUNC_LOAD, 16'($urandom), 16'($urandom_range(0, 120)),
                   16'($urandom_range(1, 24)));
      // table full, with every field at its top value
      send_item(FUNC_LOAD, 16'hffff, 16'hffff, 16'hffff);
      // zero service is reported ahead of table full
      send_item(FUNC_LOAD, 16'h0000, 16'hffff, 16'h0000);
      // first tick: from here on every load is late
      send_item(FUNC_TICK, 16'h0000, 16'h0000, 16'h0000);
      send_item(FUNC_LOAD, 16'hffff, 16'hffff, 16'hffff);
      send_item(FUNC_LOAD, 16'h0000, 16'h0000, 16'h0001);

      // --- random part: mostly ticks, which run the whole stack down and then idle;
      // late loads with full-range fields sprinkled in ---
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(FUNC_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
         else
            send_item(FUNC_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      req_tvalid <= 1'b0;

      // let the monitor's count reflect the last transfer, then drain
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("run covered %0d loads and %0d ticks, %0d results checked",
               n_loads, n_ticks, n_taken);
      $display("%0d ticks with a job running, one %0d-cycle receiver hold-off",
               busy_ticks, HOLD_CYCLES);
      if (err_count == 0 && due_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: sim.f
hdl/ljs_pkg.sv
hdl/ljs_ram.sv
hdl/ljs_ctrl.sv
hdl/ljs_rsp_reg.sv
hdl/lifo_job_scheduler.sv
hdl/ljs_checker.sv
test/ljs_monitor.sv
test/tb.sv
